// File: rtl/circov_pkg.sv
package circov_pkg;

   // radius and radius sum widths
   localparam int RAD_W = 16;
   localparam int SUM_W = RAD_W + 1;

   // world size register
   localparam int WORLD_W = 24;
   localparam logic [WORLD_W-1:0] WORLD_RESET = 24'd3276800;

   // default position format
   localparam int DEF_POS_INT_BITS  = 16;
   localparam int DEF_POS_FRAC_BITS = 8;

endpackage

// File: rtl/circov_if.sv
interface circov_req_if
   import circov_pkg::*;
   #(parameter int PW = DEF_POS_INT_BITS + DEF_POS_FRAC_BITS);
   logic             valid;
   logic             ready;
   logic [PW-1:0]    first_x;
   logic [PW-1:0]    first_y;
   logic [RAD_W-1:0] first_radius;
   logic [PW-1:0]    second_x;
   logic [PW-1:0]    second_y;
   logic [RAD_W-1:0] second_radius;

   modport source (output valid, first_x, first_y, first_radius,
                   second_x, second_y, second_radius, input ready);
   modport sink   (input valid, first_x, first_y, first_radius,
                   second_x, second_y, second_radius, output ready);
endinterface

interface circov_rsp_if
   import circov_pkg::*;
   #(parameter int PW = DEF_POS_INT_BITS + DEF_POS_FRAC_BITS);
   logic          valid;
   logic          ready;
   logic          overlapped;
   logic          coincident;
   logic [PW-1:0] new_first_x;
   logic [PW-1:0] new_first_y;
   logic [PW-1:0] new_second_x;
   logic [PW-1:0] new_second_y;

   modport source (output valid, overlapped, coincident, new_first_x, new_first_y,
                   new_second_x, new_second_y, input ready);
   modport sink   (input valid, overlapped, coincident, new_first_x, new_first_y,
                   new_second_x, new_second_y, output ready);
endinterface

// File: rtl/circle_overlap_resolve.sv
// Channel   Direction  Handshake            Payload
// req_chan  in         valid/ready          two circles: centre x, y and radius each
// rsp_chan  out        valid/ready          flags and the four resolved centre coordinates
// csr_*     in         csr_wr_en, one cycle world side length
//
// An item passes through every stage in order from the input to the output handshake:
// 4 front stages, one root stage per root bit (17), depth and product stages,
// one quotient stage per quotient bit (17) and the output stage, 41 in all.
// One item is taken every cycle while req_chan.ready is high.
// Reset (synchronous) empties all stages and loads the default world size.
// Each stage holds its item while the next is full and stalled; empty stages fill in
// behind a stalled output, so req_chan.ready only falls when every stage is full.
module circle_overlap_resolve
   import circov_pkg::*;
   #(parameter int POS_INT_BITS  = DEF_POS_INT_BITS,
     parameter int POS_FRAC_BITS = DEF_POS_FRAC_BITS)
   (input  logic               clock,
    input  logic               reset,
    circov_req_if.sink         req_chan,
    circov_rsp_if.source       rsp_chan,
    input  logic               csr_wr_en,
    input  logic [WORLD_W-1:0] csr_wr_data);

   localparam int PW    = POS_INT_BITS + POS_FRAC_BITS;
   localparam int AW    = (PW > SUM_W) ? PW : SUM_W;
   localparam int PRD_W = 2 * SUM_W;
   localparam int REM_W = PRD_W + 1;
   localparam int CW    = ((PW > WORLD_W) ? PW : WORLD_W) + 2;

   localparam int S_DIFF  = 1;
   localparam int S_SQ    = 2;
   localparam int S_HIT   = 3;
   localparam int S_RT0   = 4;
   localparam int S_DEPTH = S_RT0 + SUM_W;
   localparam int S_MUL   = S_DEPTH + 1;
   localparam int S_DV0   = S_MUL + 1;
   localparam int S_OUT   = S_DV0 + SUM_W;
   localparam int NST     = S_OUT + 1;

   typedef struct packed {
      logic [PW-1:0]    x1;
      logic [PW-1:0]    y1;
      logic [PW-1:0]    x2;
      logic [PW-1:0]    y2;
      logic [RAD_W-1:0] r1;
      logic [RAD_W-1:0] r2;
      logic [SUM_W-1:0] sum;
      logic [AW-1:0]    adx;
      logic [AW-1:0]    ady;
      logic             sgnx;
      logic             sgny;
      logic             in_box;
      logic             hit;
      logic             coinc;
      logic [PRD_W-1:0] sqx;
      logic [PRD_W-1:0] sqy;
      logic [PRD_W-1:0] sqs;
      logic [REM_W-1:0] rem;
      logic [SUM_W-1:0] root;
      logic [SUM_W-1:0] depth;
      logic [REM_W-1:0] remx;
      logic [REM_W-1:0] remy;
      logic [SUM_W-1:0] qx;
      logic [SUM_W-1:0] qy;
   } stage_type;

   stage_type          pipe_ff [NST];
   stage_type          pipe_in [NST];
   logic [NST-1:0]     vld_ff;
   logic [NST-1:0]     adv;
   logic [WORLD_W-1:0] world_ff;

   // keep circle inside the world, then saturate to the position range
   function automatic logic [PW-1:0] clamp_pos(input logic signed [CW-1:0] p_in,
                                               input logic [RAD_W-1:0] r,
                                               input logic [WORLD_W-1:0] w);
      logic signed [CW-1:0] p;
      logic signed [CW-1:0] rs;
      logic signed [CW-1:0] top;
      logic signed [CW-1:0] pmax;
      p    = p_in;
      rs   = CW'(r);
      top  = CW'(w) - rs;
      pmax = CW'({PW{1'b1}});
      if (p < rs) p = rs;
      if (p > top) p = top;
      if (p < 0) p = '0;
      if (p > pmax) p = pmax;
      return p[PW-1:0];
   endfunction

   // world size register
   always_ff @(posedge clock) begin
      if (reset) begin
         world_ff <= WORLD_RESET;
      end else if (csr_wr_en) begin
         world_ff <= csr_wr_data;
      end
   end

   // a stage moves on when it is empty or its successor moves
   always_comb begin
      adv[NST-1] = !vld_ff[NST-1] || rsp_chan.ready;
      for (int k = NST - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign req_chan.ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= (k == 0) ? req_chan.valid : vld_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   end

   // input stage
   always_comb begin
      pipe_in[0]    = '0;
      pipe_in[0].x1 = req_chan.first_x;
      pipe_in[0].y1 = req_chan.first_y;
      pipe_in[0].r1 = req_chan.first_radius;
      pipe_in[0].x2 = req_chan.second_x;
      pipe_in[0].y2 = req_chan.second_y;
      pipe_in[0].r2 = req_chan.second_radius;
   end

   for (genvar k = 1; k < NST; k++) begin : g_stage
      if (k == S_DIFF) begin : g_diff
         // centre differences, magnitudes and radius sum
         logic [PW:0] dx;
         logic [PW:0] dy;
         logic [PW:0] mx;
         logic [PW:0] my;
         always_comb begin
            pipe_in[k]      = pipe_ff[k-1];
            dx              = {1'b0, pipe_ff[k-1].x1} - {1'b0, pipe_ff[k-1].x2};
            dy              = {1'b0, pipe_ff[k-1].y1} - {1'b0, pipe_ff[k-1].y2};
            mx              = dx[PW] ? -dx : dx;
            my              = dy[PW] ? -dy : dy;
            pipe_in[k].sgnx = dx[PW];
            pipe_in[k].sgny = dy[PW];
            pipe_in[k].adx  = AW'(mx[PW-1:0]);
            pipe_in[k].ady  = AW'(my[PW-1:0]);
            pipe_in[k].sum  = SUM_W'(pipe_ff[k-1].r1) + SUM_W'(pipe_ff[k-1].r2);
         end
      end else if (k == S_SQ) begin : g_sq
         // coarse box test and the three squares
         always_comb begin
            pipe_in[k]        = pipe_ff[k-1];
            pipe_in[k].in_box = (pipe_ff[k-1].adx < AW'(pipe_ff[k-1].sum)) &&
                                (pipe_ff[k-1].ady < AW'(pipe_ff[k-1].sum));
            pipe_in[k].sqx    = PRD_W'(pipe_ff[k-1].adx[SUM_W-1:0]) *
                                PRD_W'(pipe_ff[k-1].adx[SUM_W-1:0]);
            pipe_in[k].sqy    = PRD_W'(pipe_ff[k-1].ady[SUM_W-1:0]) *
                                PRD_W'(pipe_ff[k-1].ady[SUM_W-1:0]);
            pipe_in[k].sqs    = PRD_W'(pipe_ff[k-1].sum) * PRD_W'(pipe_ff[k-1].sum);
         end
      end else if (k == S_HIT) begin : g_hit
         // squared distance against squared radius sum
         logic [REM_W-1:0] dsq;
         always_comb begin
            pipe_in[k]       = pipe_ff[k-1];
            dsq              = REM_W'(pipe_ff[k-1].sqx) + REM_W'(pipe_ff[k-1].sqy);
            pipe_in[k].hit   = pipe_ff[k-1].in_box && (dsq < REM_W'(pipe_ff[k-1].sqs));
            pipe_in[k].coinc = pipe_in[k].hit && (dsq == '0);
            pipe_in[k].rem   = dsq;
            pipe_in[k].root  = '0;
         end
      end else if (k >= S_RT0 && k < S_DEPTH) begin : g_root
         // one root bit per stage
         localparam int B = SUM_W - 1 - (k - S_RT0);
         logic [REM_W-1:0] trial;
         always_comb begin
            pipe_in[k] = pipe_ff[k-1];
            trial      = (REM_W'(pipe_ff[k-1].root) << (B + 1)) |
                         (REM_W'(1) << (2 * B));
            if (pipe_ff[k-1].rem >= trial) begin
               pipe_in[k].rem     = pipe_ff[k-1].rem - trial;
               pipe_in[k].root[B] = 1'b1;
            end
         end
      end else if (k == S_DEPTH) begin : g_depth
         always_comb begin
            pipe_in[k]       = pipe_ff[k-1];
            pipe_in[k].depth = pipe_ff[k-1].sum - pipe_ff[k-1].root;
         end
      end else if (k == S_MUL) begin : g_mul
         // magnitude times depth, per axis
         always_comb begin
            pipe_in[k]      = pipe_ff[k-1];
            pipe_in[k].remx = REM_W'(PRD_W'(pipe_ff[k-1].adx[SUM_W-1:0]) *
                                     PRD_W'(pipe_ff[k-1].depth));
            pipe_in[k].remy = REM_W'(PRD_W'(pipe_ff[k-1].ady[SUM_W-1:0]) *
                                     PRD_W'(pipe_ff[k-1].depth));
            pipe_in[k].qx   = '0;
            pipe_in[k].qy   = '0;
         end
      end else if (k >= S_DV0 && k < S_OUT) begin : g_div
         // one quotient bit per stage, divisor is twice the root
         localparam int B = SUM_W - 1 - (k - S_DV0);
         logic [REM_W-1:0] trial;
         always_comb begin
            pipe_in[k] = pipe_ff[k-1];
            trial      = REM_W'({pipe_ff[k-1].root, 1'b0}) << B;
            if (pipe_ff[k-1].remx >= trial) begin
               pipe_in[k].remx  = pipe_ff[k-1].remx - trial;
               pipe_in[k].qx[B] = 1'b1;
            end
            if (pipe_ff[k-1].remy >= trial) begin
               pipe_in[k].remy  = pipe_ff[k-1].remy - trial;
               pipe_in[k].qy[B] = 1'b1;
            end
         end
      end else begin : g_out
         // apply shifts and clamp, or pass the centres through
         logic signed [CW-1:0] sx;
         logic signed [CW-1:0] sy;
         logic                 moved;
         always_comb begin
            pipe_in[k] = pipe_ff[k-1];
            sx         = pipe_ff[k-1].sgnx ? -CW'(pipe_ff[k-1].qx) : CW'(pipe_ff[k-1].qx);
            sy         = pipe_ff[k-1].sgny ? -CW'(pipe_ff[k-1].qy) : CW'(pipe_ff[k-1].qy);
            moved      = pipe_ff[k-1].hit && !pipe_ff[k-1].coinc;
            pipe_in[k].hit = moved;
            if (moved) begin
               pipe_in[k].x1 = clamp_pos(CW'(pipe_ff[k-1].x1) + sx, pipe_ff[k-1].r1, world_ff);
               pipe_in[k].y1 = clamp_pos(CW'(pipe_ff[k-1].y1) + sy, pipe_ff[k-1].r1, world_ff);
               pipe_in[k].x2 = clamp_pos(CW'(pipe_ff[k-1].x2) - sx, pipe_ff[k-1].r2, world_ff);
               pipe_in[k].y2 = clamp_pos(CW'(pipe_ff[k-1].y2) - sy, pipe_ff[k-1].r2, world_ff);
            end
         end
      end
   end

   // stage payload registers
   always_ff @(posedge clock) begin
      for (int k = 0; k < NST; k++) begin
         if (adv[k]) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   assign rsp_chan.valid        = vld_ff[NST-1];
   assign rsp_chan.overlapped   = pipe_ff[NST-1].hit;
   assign rsp_chan.coincident   = pipe_ff[NST-1].coinc;
   assign rsp_chan.new_first_x  = pipe_ff[NST-1].x1;
   assign rsp_chan.new_first_y  = pipe_ff[NST-1].y1;
   assign rsp_chan.new_second_x = pipe_ff[NST-1].x2;
   assign rsp_chan.new_second_y = pipe_ff[NST-1].y2;

endmodule

// File: rtl/circov_check.sv
module circov_check
   import circov_pkg::*;
   #(parameter int PW = DEF_POS_INT_BITS + DEF_POS_FRAC_BITS)
   (input logic          clock,
    input logic          reset,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input logic          overlapped,
    input logic          coincident,
    input logic [PW-1:0] new_first_x,
    input logic [PW-1:0] new_second_x);

   // a result is never flagged both overlapped and coincident
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(overlapped && coincident))
      else $error("overlapped and coincident both set");

   // an empty output means the pipeline has room
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // nothing leaves the pipeline just after reset
   a_empty_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result shown straight after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(new_first_x) && $stable(new_second_x))
      else $error("stalled result changed");

endmodule

bind circle_overlap_resolve circov_check #(.PW(POS_INT_BITS + POS_FRAC_BITS)) u_circov_check (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .overlapped   (rsp_chan.overlapped),
   .coincident   (rsp_chan.coincident),
   .new_first_x  (rsp_chan.new_first_x),
   .new_second_x (rsp_chan.new_second_x));
